/* rtl/tacrf_pkg.sv */
// shared types, constants and the micro-op table of the command rate filter
`default_nettype none

package tacrf_pkg;

  localparam int AXES   = 3;
  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

  localparam int CMD_W     = 24;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DELTA_RECIPROCAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_GAIN      = 1'd1;

  localparam logic [CFG_W-1:0] DELTA_RECIPROCAL_RESET = 16'd3277;
  localparam logic [CFG_W-1:0] LAMBDA_GAIN_RESET      = 16'd512;

  // multiplier datapath: a wide operand is split into two halves
  localparam int OPA_W  = 44;
  localparam int HALF_W = 22;
  localparam int MULA_W = OPA_W - HALF_W + 1;
  localparam int OPB_W  = 22;
  localparam int PROD_W = MULA_W + OPB_W;
  localparam int ACC_W  = 64;
  localparam int SH_W   = 5;

  localparam logic signed [OPB_W-1:0] COEF_AA   = 22'sd1030226;
  localparam logic signed [OPB_W-1:0] COEF_AR   = 22'sd171652;
  localparam logic signed [OPB_W-1:0] COEF_AU   = 22'sd34341;
  localparam logic signed [OPB_W-1:0] COEF_RA   = -22'sd171652;
  localparam logic signed [OPB_W-1:0] COEF_RR   = 22'sd686817;
  localparam logic signed [OPB_W-1:0] COEF_RU   = 22'sd137363;
  localparam logic signed [OPB_W-1:0] COEF_FEED = 22'sd209715;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_LAST = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_WB,
    ST_HOLD
  } state_e;

  typedef enum logic [2:0] {
    ASEL_ANG,
    ASEL_RAT,
    ASEL_CMD,
    ASEL_V,
    ASEL_D,
    ASEL_S
  } a_sel_e;

  typedef enum logic [3:0] {
    BSEL_AA,
    BSEL_AR,
    BSEL_AU,
    BSEL_RA,
    BSEL_RR,
    BSEL_RU,
    BSEL_FEED,
    BSEL_DR,
    BSEL_LG
  } b_sel_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_NA,
    WB_NR,
    WB_V,
    WB_RATE,
    WB_D,
    WB_S,
    WB_ACC
  } wb_e;

  typedef struct packed {
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    logic            clear;
    logic [SH_W-1:0] rshift;
    wb_e             wb;
  } op_t;

  function automatic op_t op_info(input logic [OP_W-1:0] op);
    op_t o;
    o = '{a_sel: ASEL_ANG, b_sel: BSEL_AA, clear: 1'b1, rshift: 5'd20, wb: WB_NONE};
    case (op)
      4'd0:  o = '{a_sel: ASEL_ANG, b_sel: BSEL_AA,   clear: 1'b1, rshift: 5'd20, wb: WB_NONE};
      4'd1:  o = '{a_sel: ASEL_RAT, b_sel: BSEL_AR,   clear: 1'b0, rshift: 5'd20, wb: WB_NONE};
      4'd2:  o = '{a_sel: ASEL_CMD, b_sel: BSEL_AU,   clear: 1'b0, rshift: 5'd20, wb: WB_NA};
      4'd3:  o = '{a_sel: ASEL_ANG, b_sel: BSEL_RA,   clear: 1'b1, rshift: 5'd20, wb: WB_NONE};
      4'd4:  o = '{a_sel: ASEL_RAT, b_sel: BSEL_RR,   clear: 1'b0, rshift: 5'd20, wb: WB_NONE};
      4'd5:  o = '{a_sel: ASEL_CMD, b_sel: BSEL_RU,   clear: 1'b0, rshift: 5'd20, wb: WB_NR};
      4'd6:  o = '{a_sel: ASEL_CMD, b_sel: BSEL_FEED, clear: 1'b1, rshift: 5'd20, wb: WB_V};
      4'd7:  o = '{a_sel: ASEL_V,   b_sel: BSEL_DR,   clear: 1'b1, rshift: 5'd16, wb: WB_RATE};
      4'd8:  o = '{a_sel: ASEL_V,   b_sel: BSEL_LG,   clear: 1'b1, rshift: 5'd8,  wb: WB_D};
      4'd9:  o = '{a_sel: ASEL_D,   b_sel: BSEL_DR,   clear: 1'b1, rshift: 5'd16, wb: WB_S};
      4'd10: o = '{a_sel: ASEL_S,   b_sel: BSEL_DR,   clear: 1'b1, rshift: 5'd16, wb: WB_ACC};
      default: o = '{a_sel: ASEL_ANG, b_sel: BSEL_AA, clear: 1'b1, rshift: 5'd20, wb: WB_NONE};
    endcase
    return o;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = ACC_W'(64'sh7FFF_FFFF);
    lo_lim = -ACC_W'(64'sh8000_0000);
    if (x > hi_lim) begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end else if (x < lo_lim) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return x[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/three_axis_command_rate_filter_core.sv */
// three-axis command rate filter: tracking differentiator on one shared multiply-accumulate unit
`default_nettype none

// Takes one beat of roll, pitch and yaw commands (Q3.20) and returns one beat of filtered
// rates and accelerations (Q11.20, saturated). All arithmetic runs on a single 23x22 signed
// multiplier with a 64-bit accumulator, stepped by a small sequencer through eleven
// multiply ops per axis; each op feeds the wide operand in two halves, and ops that produce
// a value then pass through a write-back state that rounds and stores it. A new command
// beat is taken only once all three axes are done and the result is handed off. A finished
// result waits in its own output register, so the next command beat is taken while it is
// still unread. The user must write the delta reciprocal and lambda registers through the
// cfg port only while the block is idle; the block itself does not enforce this.
module three_axis_command_rate_filter_core
  import tacrf_pkg::*;
(
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // fields from bit 0: roll_command, pitch_command, yaw_command
  input  wire [AXES*CMD_W-1:0]         s_axis_tdata,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // fields from bit 0: roll_rate, pitch_rate, yaw_rate,
  // roll_acceleration, pitch_acceleration, yaw_acceleration
  output logic [2*AXES*OUT_W-1:0]      m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  input  wire                          cfg_we_i,
  input  wire [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire [CFG_W-1:0]              cfg_wdata_i
);

  state_e state_q, state_d;
  logic [AXIS_W-1:0] axis_q;
  logic [OP_W-1:0]   op_q;

  logic [CFG_W-1:0] dr_q, lg_q;

  logic signed [CMD_W-1:0] cmd_q [AXES];
  logic signed [OUT_W-1:0] ang_q [AXES];
  logic signed [OUT_W-1:0] rat_q [AXES];

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [OUT_W-1:0] na_q, nr_q;
  logic signed [OUT_W:0]   ud_q;
  logic signed [OUT_W+1:0] v_q;
  logic signed [OPA_W-1:0] d_q, s_q;

  logic signed [OUT_W-1:0] rate_w_q  [AXES];
  logic signed [OUT_W-1:0] accel_w_q [AXES];
  logic signed [OUT_W-1:0] rate_o_q  [AXES];
  logic signed [OUT_W-1:0] accel_o_q [AXES];
  logic out_valid_q;

  op_t cur;
  logic in_accept, load_out, wb_en, step_op, next_axis;

  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [OUT_W-1:0]  sat_val;

  assign cur = op_info(op_q);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_LO;
      end
      ST_LO: state_d = ST_HI;
      ST_HI: begin
        state_d = (cur.wb != WB_NONE) ? ST_WB : ST_LO;
      end
      ST_WB: begin
        if (op_q == OP_LAST && axis_q == AXIS_W'(AXES - 1)) begin
          state_d = ST_HOLD;
        end else begin
          state_d = ST_LO;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    wb_en         = 1'b0;
    step_op       = 1'b0;
    next_axis     = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_HI:   step_op = (cur.wb == WB_NONE);
      ST_WB: begin
        wb_en     = 1'b1;
        step_op   = (op_q != OP_LAST);
        next_axis = (op_q == OP_LAST) && (axis_q != AXIS_W'(AXES - 1));
      end
      ST_HOLD: load_out = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= '0;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        axis_q <= '0;
        op_q   <= '0;
      end else if (step_op) begin
        op_q <= op_q + OP_W'(1);
      end else if (next_axis) begin
        op_q   <= '0;
        axis_q <= axis_q + AXIS_W'(1);
      end
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dr_q <= DELTA_RECIPROCAL_RESET;
      lg_q <= LAMBDA_GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DELTA_RECIPROCAL: dr_q <= cfg_wdata_i;
        REG_LAMBDA_GAIN:      lg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- shared multiply-accumulate ----------------
  always_comb begin
    case (cur.a_sel)
      ASEL_ANG: opa = OPA_W'(ang_q[axis_q]);
      ASEL_RAT: opa = OPA_W'(rat_q[axis_q]);
      ASEL_CMD: opa = OPA_W'(cmd_q[axis_q]);
      ASEL_V:   opa = OPA_W'(v_q);
      ASEL_D:   opa = d_q;
      ASEL_S:   opa = s_q;
      default:  opa = '0;
    endcase
  end

  always_comb begin
    case (cur.b_sel)
      BSEL_AA:   opb = COEF_AA;
      BSEL_AR:   opb = COEF_AR;
      BSEL_AU:   opb = COEF_AU;
      BSEL_RA:   opb = COEF_RA;
      BSEL_RR:   opb = COEF_RR;
      BSEL_RU:   opb = COEF_RU;
      BSEL_FEED: opb = COEF_FEED;
      BSEL_DR:   opb = $signed({{(OPB_W-CFG_W){1'b0}}, dr_q});
      BSEL_LG:   opb = $signed({{(OPB_W-CFG_W){1'b0}}, lg_q});
      default:   opb = '0;
    endcase
  end

  // low half is unsigned, high half carries the sign
  assign mul_a = (state_q == ST_HI) ? MULA_W'($signed(opa[OPA_W-1:HALF_W]))
                                    : $signed({{(MULA_W-HALF_W){1'b0}}, opa[HALF_W-1:0]});
  assign prod     = PROD_W'(mul_a) * PROD_W'(opb);
  assign prod_ext = ACC_W'(prod);

  // rounding offset is preloaded so the write-back is a plain shift
  assign rnd = $signed(ACC_W'(1) << (cur.rshift - SH_W'(1)));

  always_comb begin
    acc_d = acc_q;
    case (state_q)
      ST_LO:   acc_d = (cur.clear ? rnd : acc_q) + prod_ext;
      ST_HI:   acc_d = acc_q + (prod_ext <<< HALF_W);
      default: acc_d = acc_q;
    endcase
  end

  assign shifted = acc_q >>> cur.rshift;
  assign sat_val = sat32(shifted);

  // ---------------- state and results ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < AXES; j++) begin
        ang_q[j] <= '0;
        rat_q[j] <= '0;
      end
    end else if (wb_en && cur.wb == WB_NR) begin
      ang_q[axis_q] <= na_q;
      rat_q[axis_q] <= sat_val;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_accept) begin
      for (int j = 0; j < AXES; j++) begin
        cmd_q[j] <= $signed(s_axis_tdata[CMD_W*j +: CMD_W]);
      end
    end
    if (wb_en) begin
      case (cur.wb)
        WB_NA: na_q <= sat_val;
        WB_NR: begin
          nr_q <= sat_val;
          ud_q <= (OUT_W+1)'(cmd_q[axis_q]) - (OUT_W+1)'(na_q);
        end
        WB_V:    v_q <= (OUT_W+2)'(nr_q) + $signed(shifted[OUT_W+1:0]);
        WB_RATE: rate_w_q[axis_q] <= sat_val;
        WB_D:    d_q <= OPA_W'(ud_q) - $signed(shifted[OPA_W-1:0]);
        WB_S:    s_q <= $signed(shifted[OPA_W-1:0]);
        WB_ACC:  accel_w_q[axis_q] <= sat_val;
        default: ;
      endcase
    end
    if (load_out) begin
      for (int j = 0; j < AXES; j++) begin
        rate_o_q[j]  <= rate_w_q[j];
        accel_o_q[j] <= accel_w_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      m_axis_tdata[OUT_W*j +: OUT_W]          = rate_o_q[j];
      m_axis_tdata[OUT_W*(AXES+j) +: OUT_W]   = accel_o_q[j];
    end
  end

`ifndef SYNTHESIS
  // a beat is taken only when the sequencer is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input beat accepted while busy");

  // write-back cycles only follow ops that produce a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |-> (cur.wb != WB_NONE))
    else $error("write-back on an accumulate-only op");

  // the op and axis counters stay inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (op_q <= OP_LAST && axis_q <= AXIS_W'(AXES - 1)))
    else $error("sequencer counter out of range");

  // a pending result is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
